// ===== src/gbvs_pkg.sv =====
// Shared types, codes and fixed-point helpers for the grid velocity sampler.
package gbvs_pkg;

  localparam int NX_MAX_DEF       = 32;
  localparam int NZ_MAX_DEF       = 1024;
  localparam int USE_VERTICAL_DEF = 1;
  // start beat to result strobe, in cycles
  localparam int LATENCY          = 13;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_QUERY  = 2'd1,
    OP_ZQUERY = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Z  = 3'd1,
    CFG_INV_SP_X  = 3'd2,
    CFG_INV_SP_Z  = 3'd3,
    CFG_GRID_NX   = 3'd4,
    CFG_GRID_NZ   = 3'd5,
    CFG_VEL_CORR  = 3'd6,
    CFG_ZONE_ID   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [14:0]        grid_index;
    logic signed [31:0] grid_vel_x;
    logic signed [31:0] grid_vel_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [3:0]         particle_zone;
    logic               batch_end;
  } gbvs_in_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_z;
    logic               updated;
    logic               batch_end_out;
  } gbvs_out_t;

  // lerp after the difference step
  typedef struct packed {
    logic signed [31:0] a;
    logic [32:0]        md;
    logic               neg;
  } lerp_d_t;

  // lerp after the split multiply
  typedef struct packed {
    logic signed [31:0] a;
    logic [48:0]        p_hi;
    logic [64:0]        p_lo;
    logic               neg;
  } lerp_m_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic lerp_d_t lerp_diff(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic fneg);
    logic signed [32:0] diff;
    lerp_d_t r;
    diff  = 33'(b) - 33'(a);
    r.a   = a;
    r.md  = diff[32] ? (~diff + 33'd1) : diff;
    r.neg = fneg ^ diff[32];
    return r;
  endfunction

  // |f| is 48 bits: low 32 and high 16 bits multiplied apart
  function automatic lerp_m_t lerp_mul(input lerp_d_t d, input logic [47:0] mf);
    lerp_m_t r;
    r.a    = d.a;
    r.neg  = d.neg;
    r.p_lo = 65'(mf[31:0]) * 65'(d.md);
    r.p_hi = 49'(mf[47:32]) * 49'(d.md);
    return r;
  endfunction

  function automatic logic signed [31:0] lerp_fin(input lerp_m_t m);
    logic [80:0]        p;
    logic [64:0]        q;
    logic [34:0]        mg;
    logic signed [35:0] sum;
    p   = {m.p_hi, 32'd0} + 81'(m.p_lo);
    q   = p[80:16];
    // product magnitude capped at 2^34
    mg  = (q > 65'h4_0000_0000) ? 35'h4_0000_0000 : q[34:0];
    sum = 36'(m.a) + (m.neg ? -$signed({1'b0, mg}) : $signed({1'b0, mg}));
    return sat32(sum);
  endfunction

endpackage

// ===== src/grid_bilinear_velocity_sampler_top.sv =====
// Top level of the bilinear grid velocity sampler: config, pipeline and grid stores.
//
// Takes one beat per clock (writes and queries mixed freely) and never stalls:
// busy is high only during reset. A query (op 1 bilinear, op 2 column-0 z
// only) gives one result strobe; a grid write (op 0) or op 3 gives none. The
// receiver cannot hold results off, so rsp/rsp_valid must be taken the cycle
// they appear. The pipeline chain is: offset, scale multiply, cell/fraction,
// address multiply, registered store read, then two interpolation passes (z,
// then x) of three stages each (difference, split 48x33 multiply, sum and
// saturate), and the output register with correction. Each store is kept as
// two copies, one read at the lower column's two rows and one at the upper
// column's, so all four neighbors come out in the same cycle. Writes land in
// the same stage that reads, so a query sees every write issued before it.
// Store contents are undefined after reset. Config registers are write-only
// and take effect on queries in flight, so the user must write them only
// while the block is idle; the block itself does not enforce this.
module grid_bilinear_velocity_sampler_top #(
  parameter int NX_MAX       = gbvs_pkg::NX_MAX_DEF,
  parameter int NZ_MAX       = gbvs_pkg::NZ_MAX_DEF,
  parameter int USE_VERTICAL = gbvs_pkg::USE_VERTICAL_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  gbvs_pkg::gbvs_in_t  req,
  output logic                rsp_valid,
  output gbvs_pkg::gbvs_out_t rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import gbvs_pkg::*;

  localparam int DEPTH = NX_MAX * NZ_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = (NX_MAX > 1) ? $clog2(NX_MAX) : 1;
  localparam int CZW   = $clog2(NZ_MAX);
  localparam int NXW   = $clog2(NX_MAX + 1);
  localparam int NZW   = $clog2(NZ_MAX + 1);

  // ---------------- configuration ----------------
  logic signed [31:0] origin_x, origin_z, vel_corr;
  logic [31:0]        inv_x, inv_z;
  logic [5:0]         grid_nx;
  logic [10:0]        grid_nz;
  logic [3:0]         zone_id;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
      inv_x    <= 32'd65536;
      inv_z    <= 32'd65536;
      grid_nx  <= 6'd1;
      grid_nz  <= 11'd1;
      vel_corr <= '0;
      zone_id  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x <= cfg_data;
        CFG_ORIGIN_Z: origin_z <= cfg_data;
        CFG_INV_SP_X: inv_x    <= cfg_data;
        CFG_INV_SP_Z: inv_z    <= cfg_data;
        CFG_GRID_NX:  grid_nx  <= cfg_data[5:0];
        CFG_GRID_NZ:  grid_nz  <= cfg_data[10:0];
        CFG_VEL_CORR: vel_corr <= cfg_data;
        CFG_ZONE_ID:  zone_id  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // grid size in use: 0 acts as 1, oversize acts as the maximum
  logic [NXW-1:0] nx_eff;
  logic [NZW-1:0] nz_eff;
  logic [31:0]    nxm1, nzm1;
  assign nx_eff = (grid_nx == '0) ? NXW'(1) :
                  (32'(grid_nx) > NX_MAX) ? NXW'(NX_MAX) : NXW'(grid_nx);
  assign nz_eff = (grid_nz == '0) ? NZW'(1) :
                  (32'(grid_nz) > NZ_MAX) ? NZW'(NZ_MAX) : NZW'(grid_nz);
  assign nxm1 = 32'(nx_eff) - 32'd1;
  assign nzm1 = 32'(nz_eff) - 32'd1;

  // ---------------- stage 1: input register ----------------
  logic     s1_v;
  gbvs_in_t s1;

  // ---------------- stage 2: offset from origin ----------------
  logic               s2_q, s2_w, s2_zo, s2_match, s2_be;
  logic [14:0]        s2_widx;
  logic signed [31:0] s2_wx, s2_wz;
  logic [31:0]        s2_dmx, s2_dmz;
  logic               s2_dnx, s2_dnz;
  logic signed [32:0] dx, dz;
  logic [32:0]        dx_abs, dz_abs;

  assign dx     = 33'(s1.pos_x) - 33'(origin_x);
  assign dz     = 33'(s1.pos_z) - 33'(origin_z);
  assign dx_abs = dx[32] ? (~dx + 33'd1) : dx;
  assign dz_abs = dz[32] ? (~dz + 33'd1) : dz;

  // ---------------- stage 3: scale by inverse spacing ----------------
  logic               s3_q, s3_w, s3_zo, s3_match, s3_be;
  logic [14:0]        s3_widx;
  logic signed [31:0] s3_wx, s3_wz;
  logic [47:0]        s3_mx, s3_mz;
  logic               s3_nx, s3_nz;
  logic [63:0]        px, pz;

  assign px = 64'(s2_dmx) * 64'(inv_x);
  assign pz = 64'(s2_dmz) * 64'(inv_z);

  // ---------------- stage 4: cell and fraction ----------------
  logic               s4_q, s4_w, s4_match, s4_be;
  logic [14:0]        s4_widx;
  logic signed [31:0] s4_wx, s4_wz;
  logic [CXW-1:0]     s4_cx, s4_cx1;
  logic [CZW-1:0]     s4_cz, s4_cz1;
  logic [47:0]        s4_mfx, s4_mfz;
  logic               s4_fnx, s4_fnz;

  logic [31:0]    qx, qz, cellx, cellz;
  logic [CXW-1:0] cx_c, cx1_c;
  logic [CZW-1:0] cz_c, cz1_c;
  logic [47:0]    mfx_c, mfz_c;
  logic           fnx_c;

  always_comb begin
    qx    = s3_mx[47:16];
    qz    = s3_mz[47:16];
    // below origin: cell 0, negative fraction
    cellx = s3_nx ? 32'd0 : ((qx > nxm1) ? nxm1 : qx);
    cellz = s3_nz ? 32'd0 : ((qz > nzm1) ? nzm1 : qz);
    cx_c  = CXW'(cellx);
    cz_c  = CZW'(cellz);
    mfx_c = s3_nx ? s3_mx : (s3_mx - (48'(cellx) << 16));
    mfz_c = s3_nz ? s3_mz : (s3_mz - (48'(cellz) << 16));
    fnx_c = s3_nx;
    if (s3_zo) begin
      // column 0 only
      cx_c  = '0;
      mfx_c = '0;
      fnx_c = 1'b0;
    end
    // edge neighbors replicate the node
    cx1_c = (32'(cx_c) < nxm1 && !s3_zo) ? cx_c + CXW'(1) : cx_c;
    cz1_c = (32'(cz_c) < nzm1) ? cz_c + CZW'(1) : cz_c;
  end

  // ---------------- stage 5: store addresses ----------------
  logic               s5_q, s5_we, s5_match, s5_be;
  logic [AW-1:0]      s5_waddr;
  logic signed [31:0] s5_wx, s5_wz;
  logic [AW-1:0]      s5_a00, s5_a01, s5_a10, s5_a11;
  logic [47:0]        s5_mfx, s5_mfz;
  logic               s5_fnx, s5_fnz;
  logic [AW:0]        row0, row1;

  assign row0 = (AW+1)'(s4_cx)  * (AW+1)'(nz_eff);
  assign row1 = (AW+1)'(s4_cx1) * (AW+1)'(nz_eff);

  // ---------------- stage 6: store read ----------------
  logic               s6_q, s6_match, s6_be;
  logic signed [31:0] x00, x01, x10, x11, z00, z01, z10, z11;
  logic [47:0]        s6_mfx, s6_mfz;
  logic               s6_fnx, s6_fnz;

  logic signed [31:0] xs_lo [DEPTH];
  logic signed [31:0] xs_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (s5_we) begin
      xs_lo[s5_waddr] <= s5_wx;
      xs_hi[s5_waddr] <= s5_wx;
    end
    x00 <= xs_lo[s5_a00];
    x01 <= xs_lo[s5_a01];
    x10 <= xs_hi[s5_a10];
    x11 <= xs_hi[s5_a11];
  end

  generate
    if (USE_VERTICAL != 0) begin : g_zstore
      logic signed [31:0] zs_lo [DEPTH];
      logic signed [31:0] zs_hi [DEPTH];
      always_ff @(posedge clk) begin
        if (s5_we) begin
          zs_lo[s5_waddr] <= s5_wz;
          zs_hi[s5_waddr] <= s5_wz;
        end
        z00 <= zs_lo[s5_a00];
        z01 <= zs_lo[s5_a01];
        z10 <= zs_hi[s5_a10];
        z11 <= zs_hi[s5_a11];
      end
    end else begin : g_nozstore
      assign z00 = '0;
      assign z01 = '0;
      assign z10 = '0;
      assign z11 = '0;
    end
  endgenerate

  // ---------------- stages 7-9: interpolate along z ----------------
  logic        s7_q, s7_match, s7_be, s7_fnx;
  logic [47:0] s7_mfx, s7_mfz;
  lerp_d_t     s7_x0, s7_x1, s7_z0, s7_z1;

  logic        s8_q, s8_match, s8_be, s8_fnx;
  logic [47:0] s8_mfx;
  lerp_m_t     s8_x0, s8_x1, s8_z0, s8_z1;

  logic               s9_q, s9_match, s9_be, s9_fnx;
  logic [47:0]        s9_mfx;
  logic signed [31:0] s9_x0, s9_x1, s9_z0, s9_z1;

  // ---------------- stages 10-12: interpolate along x ----------------
  logic        s10_q, s10_match, s10_be;
  logic [47:0] s10_mfx;
  lerp_d_t     s10_x, s10_z;

  logic    s11_q, s11_match, s11_be;
  lerp_m_t s11_x, s11_z;

  logic               s12_q, s12_match, s12_be;
  logic signed [31:0] s12_vx, s12_vz;

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_q <= 1'b0; s2_w <= 1'b0;
      s3_q <= 1'b0; s3_w <= 1'b0;
      s4_q <= 1'b0; s4_w <= 1'b0;
      s5_q <= 1'b0; s5_we <= 1'b0;
      s6_q <= 1'b0; s7_q <= 1'b0; s8_q <= 1'b0; s9_q <= 1'b0;
      s10_q <= 1'b0; s11_q <= 1'b0; s12_q <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_v  <= start && !busy;
      s2_q  <= s1_v && (s1.op == OP_QUERY || s1.op == OP_ZQUERY);
      s2_w  <= s1_v && (s1.op == OP_WRITE);
      s3_q  <= s2_q;  s3_w <= s2_w;
      s4_q  <= s3_q;  s4_w <= s3_w;
      s5_q  <= s4_q;
      // writes beyond the store are dropped
      s5_we <= s4_w && (32'(s4_widx) < DEPTH);
      s6_q  <= s5_q;  s7_q <= s6_q;  s8_q <= s7_q;  s9_q <= s8_q;
      s10_q <= s9_q;  s11_q <= s10_q; s12_q <= s11_q;
      rsp_valid <= s12_q;
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk) begin
    s1 <= req;

    s2_zo    <= (s1.op == OP_ZQUERY);
    s2_match <= (s1.particle_zone == zone_id);
    s2_be    <= s1.batch_end;
    s2_widx  <= s1.grid_index;
    s2_wx    <= s1.grid_vel_x;
    s2_wz    <= s1.grid_vel_z;
    s2_dmx   <= dx_abs[31:0];
    s2_dmz   <= dz_abs[31:0];
    s2_dnx   <= dx[32];
    s2_dnz   <= dz[32];

    s3_zo    <= s2_zo;
    s3_match <= s2_match;
    s3_be    <= s2_be;
    s3_widx  <= s2_widx;
    s3_wx    <= s2_wx;
    s3_wz    <= s2_wz;
    s3_mx    <= px[63:16];
    s3_mz    <= pz[63:16];
    s3_nx    <= s2_dnx;
    s3_nz    <= s2_dnz;

    s4_match <= s3_match;
    s4_be    <= s3_be;
    s4_widx  <= s3_widx;
    s4_wx    <= s3_wx;
    s4_wz    <= s3_wz;
    s4_cx    <= cx_c;
    s4_cx1   <= cx1_c;
    s4_cz    <= cz_c;
    s4_cz1   <= cz1_c;
    s4_mfx   <= mfx_c;
    s4_mfz   <= mfz_c;
    s4_fnx   <= fnx_c;
    s4_fnz   <= s3_nz;

    s5_match <= s4_match;
    s5_be    <= s4_be;
    s5_waddr <= AW'(s4_widx);
    s5_wx    <= s4_wx;
    s5_wz    <= s4_wz;
    s5_a00   <= AW'(row0 + (AW+1)'(s4_cz));
    s5_a01   <= AW'(row0 + (AW+1)'(s4_cz1));
    s5_a10   <= AW'(row1 + (AW+1)'(s4_cz));
    s5_a11   <= AW'(row1 + (AW+1)'(s4_cz1));
    s5_mfx   <= s4_mfx;
    s5_mfz   <= s4_mfz;
    s5_fnx   <= s4_fnx;
    s5_fnz   <= s4_fnz;

    s6_match <= s5_match;
    s6_be    <= s5_be;
    s6_mfx   <= s5_mfx;
    s6_mfz   <= s5_mfz;
    s6_fnx   <= s5_fnx;
    s6_fnz   <= s5_fnz;

    s7_match <= s6_match;
    s7_be    <= s6_be;
    s7_mfx   <= s6_mfx;
    s7_mfz   <= s6_mfz;
    s7_fnx   <= s6_fnx;
    s7_x0    <= lerp_diff(x00, x01, s6_fnz);
    s7_x1    <= lerp_diff(x10, x11, s6_fnz);
    s7_z0    <= lerp_diff(z00, z01, s6_fnz);
    s7_z1    <= lerp_diff(z10, z11, s6_fnz);

    s8_match <= s7_match;
    s8_be    <= s7_be;
    s8_mfx   <= s7_mfx;
    s8_fnx   <= s7_fnx;
    s8_x0    <= lerp_mul(s7_x0, s7_mfz);
    s8_x1    <= lerp_mul(s7_x1, s7_mfz);
    s8_z0    <= lerp_mul(s7_z0, s7_mfz);
    s8_z1    <= lerp_mul(s7_z1, s7_mfz);

    s9_match <= s8_match;
    s9_be    <= s8_be;
    s9_mfx   <= s8_mfx;
    s9_fnx   <= s8_fnx;
    s9_x0    <= lerp_fin(s8_x0);
    s9_x1    <= lerp_fin(s8_x1);
    s9_z0    <= lerp_fin(s8_z0);
    s9_z1    <= lerp_fin(s8_z1);

    s10_match <= s9_match;
    s10_be    <= s9_be;
    s10_mfx   <= s9_mfx;
    s10_x     <= lerp_diff(s9_x0, s9_x1, s9_fnx);
    s10_z     <= lerp_diff(s9_z0, s9_z1, s9_fnx);

    s11_match <= s10_match;
    s11_be    <= s10_be;
    s11_x     <= lerp_mul(s10_x, s10_mfx);
    s11_z     <= lerp_mul(s10_z, s10_mfx);

    s12_match <= s11_match;
    s12_be    <= s11_be;
    s12_vx    <= lerp_fin(s11_x);
    s12_vz    <= lerp_fin(s11_z);

    // output: correction, zone gate, vertical disable
    rsp.vel_x         <= s12_match ? sat32(36'(s12_vx) - 36'(vel_corr)) : '0;
    rsp.vel_z         <= (s12_match && USE_VERTICAL != 0) ? s12_vz : '0;
    rsp.updated       <= s12_match;
    rsp.batch_end_out <= s12_be;
  end

endmodule

// ===== src/gbvs_checker.sv =====
// Port-level checks for the grid velocity sampler, bound to the top level.
module gbvs_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input gbvs_pkg::gbvs_in_t  req,
  input logic                rsp_valid,
  input gbvs_pkg::gbvs_out_t rsp
);
  import gbvs_pkg::*;

  logic query_beat;
  assign query_beat = start && !busy && (req.op == OP_QUERY || req.op == OP_ZQUERY);

  a_query_gets_result: assert property (@(posedge clk) disable iff (rst)
    query_beat |-> ##LATENCY rsp_valid)
    else $error("query beat without result");

  a_result_has_query: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $past(query_beat, LATENCY))
    else $error("result without query beat");

  a_batch_end_follows: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.batch_end_out == $past(req.batch_end, LATENCY))
    else $error("batch_end_out mismatch");

  a_mismatch_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.updated) |-> (rsp.vel_x == 0 && rsp.vel_z == 0))
    else $error("zone mismatch result not zero");

endmodule

bind grid_bilinear_velocity_sampler_top gbvs_checker u_gbvs_checker (.*);

// ===== tb/sv/grid_bilinear_velocity_sampler_top_test.sv =====
// Self-checking testbench for the bilinear grid velocity sampler.
module grid_bilinear_velocity_sampler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gbvs_pkg::*;

  localparam int NXM        = NX_MAX_DEF;
  localparam int NZM        = NZ_MAX_DEF;
  localparam int DEPTH      = NXM * NZM;
  localparam int CYCLE_CAP  = 300000;
  localparam int RAND_BEATS = 55;   // random beats per phase from phase 2 on, after the node loads

  logic      clk, rst, start, busy, rsp_valid, cfg_valid, cfg_ready;
  gbvs_in_t  req;
  gbvs_out_t rsp;
  cfg_idx_t  cfg_index;
  logic [31:0] cfg_data;

  grid_bilinear_velocity_sampler_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .rsp_valid(rsp_valid), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow of the config registers, updated on each accepted config beat.
  logic signed [31:0] org_x = 0, org_z = 0, corr = 0;
  logic [31:0] inv_x = 32'h10000, inv_z = 32'h10000;
  logic [5:0]  nx_reg = 1;
  logic [10:0] nz_reg = 1;
  logic [3:0]  zone_reg = 0;

  // Shadow of the two velocity stores.
  logic [31:0] xs_mem [DEPTH];
  logic [31:0] zs_mem [DEPTH];

  gbvs_in_t  beats_pending [$];   // stimulus not yet accepted
  gbvs_out_t samples_due [$];     // expected results, oldest first
  int  fails;
  int  cycles;
  bit  calm;                      // no idling on the sender while set

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // f*d/2^16, truncated toward zero, magnitude capped at 2^34
  function automatic longint scale_q16(longint f, longint d);
    logic [127:0] p;
    longint r;
    p = (128'(f < 0 ? -f : f) * 128'(d < 0 ? -d : d)) >> 16;
    r = (p > (128'(1) << 34)) ? (64'sd1 <<< 34) : longint'(p[63:0]);
    return ((f < 0) != (d < 0)) ? -r : r;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return clamp32(a + scale_q16(f, b - a));
  endfunction

  function automatic int unsigned eff_n(int unsigned r, int unsigned mx);
    if (r == 0) return 1;
    return (r > mx) ? mx : r;
  endfunction

  // Cell index and Q16.16 fraction of one coordinate.
  function automatic int unsigned find_cell(logic signed [31:0] p, logic signed [31:0] o,
                                            logic [31:0] inv, int unsigned n,
                                            output longint fr);
    longint d, s;
    logic [127:0] m;
    int unsigned c;
    d = longint'(p) - longint'(o);
    m = (128'(d < 0 ? -d : d) * 128'(inv)) >> 16;
    s = (d < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
    c = 0;
    if (s >= 0) c = ((s >>> 16) > longint'(n - 1)) ? n - 1 : int'(s >>> 16);
    fr = s - (longint'(c) <<< 16);
    return c;
  endfunction

  function automatic longint node(bit zsel, int unsigned i);
    return zsel ? longint'($signed(zs_mem[i])) : longint'($signed(xs_mem[i]));
  endfunction

  function automatic longint interp_store(bit zsel, int unsigned a, int unsigned nz, bit zn,
                                          bit xn, longint fx, longint fz, bit zonly);
    longint v00, v01, v10, v11, v0;
    v00 = node(zsel, a);
    v01 = zn ? node(zsel, a + 1) : v00;
    v0  = blend(v00, v01, fz);
    if (zonly) return v0;
    v10 = xn ? node(zsel, a + nz) : v00;
    v11 = xn ? (zn ? node(zsel, a + nz + 1) : v10) : v01;
    return blend(v0, blend(v10, v11, fz), fx);
  endfunction

  // Apply one accepted beat to the shadow state; queue its result if any.
  task automatic apply_beat(gbvs_in_t b);
    gbvs_out_t o;
    bit zonly;
    int unsigned nx, nz, cx, cz, a;
    longint fx, fz, vx;
    o = '0;
    fx = 0;
    cx = 0;
    case (op_t'(b.op))
      OP_WRITE: begin
        xs_mem[b.grid_index] = b.grid_vel_x;
        zs_mem[b.grid_index] = b.grid_vel_z;
      end
      OP_NONE: ;
      default: begin
        o.batch_end_out = b.batch_end;
        if (b.particle_zone == zone_reg) begin
          zonly = (op_t'(b.op) == OP_ZQUERY);
          nx = zonly ? 1 : eff_n(nx_reg, NXM);
          nz = eff_n(nz_reg, NZM);
          if (!zonly) cx = find_cell(b.pos_x, org_x, inv_x, nx, fx);
          cz = find_cell(b.pos_z, org_z, inv_z, nz, fz);
          a  = nz * cx + cz;
          vx = interp_store(0, a, nz, cz < nz - 1, cx < nx - 1, fx, fz, zonly);
          o.vel_x = 32'(clamp32(vx - longint'(corr)));
          if (USE_VERTICAL_DEF != 0)
            o.vel_z = 32'(interp_store(1, a, nz, cz < nz - 1, cx < nx - 1, fx, fz, zonly));
          o.updated = 1'b1;
        end
        samples_due.push_back(o);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      if (start && !busy) begin
        apply_beat(req);
        void'(beats_pending.pop_front());
      end
      // one assignment to start per edge; it stays high across back-to-back beats
      if (beats_pending.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
        start <= 1'b1;
        req   <= beats_pending[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    gbvs_out_t e;
    if (!rst && rsp_valid) begin
      if (samples_due.size() == 0) begin
        $error("result beat with nothing expected: %p", rsp);
        fails++;
      end else begin
        e = samples_due.pop_front();
        if (rsp.vel_x !== e.vel_x) begin
          $error("vel_x expected %h got %h", e.vel_x, rsp.vel_x); fails++;
        end
        if (rsp.vel_z !== e.vel_z) begin
          $error("vel_z expected %h got %h", e.vel_z, rsp.vel_z); fails++;
        end
        if (rsp.updated !== e.updated) begin
          $error("updated expected %b got %b", e.updated, rsp.updated); fails++;
        end
        if (rsp.batch_end_out !== e.batch_end_out) begin
          $error("batch_end_out expected %b got %b", e.batch_end_out, rsp.batch_end_out);
          fails++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic gbvs_in_t mk(op_t op, logic [14:0] idx, logic [31:0] vx,
                                  logic [31:0] vz, logic [31:0] px, logic [31:0] pz,
                                  logic [3:0] zn, logic be);
    gbvs_in_t b;
    b.op = op; b.grid_index = idx; b.grid_vel_x = vx; b.grid_vel_z = vz;
    b.pos_x = px; b.pos_z = pz; b.particle_zone = zn; b.batch_end = be;
    return b;
  endfunction

  // Position spread over the grid, a bit past both ends; sometimes anywhere.
  function automatic logic [31:0] pick_pos(logic signed [31:0] o, logic [31:0] inv,
                                           int unsigned n);
    longint span, off;
    if ($urandom_range(99) < 15) return $urandom;
    span = (longint'(n) <<< 32) / longint'(inv);
    if (span < 8) span = 8;
    off = ((span * 5 / 4) / 1024) * longint'($urandom_range(0, 1024)) - span / 8;
    return 32'(clamp32(longint'(o) + off));
  endfunction

  function automatic logic [31:0] pick_vel();
    return ($urandom_range(3) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'h80000)))
                                              - 32'sh40000;
  endfunction

  // Config beat; valid stays high for a following write, caller lowers it.
  task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X: org_x    = v;
      CFG_ORIGIN_Z: org_z    = v;
      CFG_INV_SP_X: inv_x    = v;
      CFG_INV_SP_Z: inv_z    = v;
      CFG_GRID_NX:  nx_reg   = v[5:0];
      CFG_GRID_NZ:  nz_reg   = v[10:0];
      CFG_VEL_CORR: corr     = v;
      CFG_ZONE_ID:  zone_reg = v[3:0];
    endcase
  endtask

  task automatic drain();
    while (beats_pending.size() > 0 || samples_due.size() > 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    int unsigned nx, nz, used, k, r;
    logic [31:0] v[8];
    logic [3:0] zn;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_ORIGIN_X;
    cfg_data = '0;
    start = 1'b0;
    req = '0;
    fails = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 12; ph++) begin
      // origin_x, origin_z, inv_x, inv_z, nx, nz, correction, zone
      case (ph)
        1: v = '{0, 0, 32'h10000, 32'h10000, 4, 4, 0, 3};
        2: v = '{$urandom_range(0, 32'h40000), 32'hFFFE0000, 32'h8000, 32'h28000, 0, 8,
                 $urandom, $urandom_range(15)};
        3: v = '{32'hFFFF0000, 32'h30000, 32'h4000, 32'h10000, 63, 2, 32'h18000, 15};
        4: v = '{0, 32'h8000, 32'h10000, 32'h20000, 1, 2047, 32'hFFFF8000, 9};
        5: v = '{32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1, 32, 3, 32'h80000000, 0};
        6: v = '{32'h7FFFFFFF, 32'h80000000, 1, 32'hFFFFFFFF, 5, 0, 32'h7FFFFFFF, 6};
        default: v = '{$urandom, $urandom,
                       ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h1000, 32'h80000),
                       ($urandom_range(4) == 0) ? $urandom : $urandom_range(32'h1000, 32'h80000),
                       $urandom_range(0, 63), $urandom_range(0, 20),
                       $urandom, $urandom_range(15)};
      endcase
      if (ph > 0) begin
        for (int i = 0; i < 8; i++) cfg_write(cfg_idx_t'(i), v[i]);
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      calm = (ph == 8);
      nx = eff_n(nx_reg, NXM);
      nz = eff_n(nz_reg, NZM);
      used = nx * nz;

      // Load every node in use, so no query reads an unwritten node.
      for (k = 0; k < used; k++) begin
        if (ph == 1)  // alternating extremes drive the interpolation into saturation
          beats_pending.push_back(mk(OP_WRITE, k, k[0] ? 32'h80000000 : 32'h7FFFFFFF,
                                     k[0] ? 32'h7FFFFFFF : 32'h80000000, 0, 0, 0, 0));
        else
          beats_pending.push_back(mk(OP_WRITE, k, pick_vel(), pick_vel(), $urandom,
                                     $urandom, $urandom, $urandom));
      end

      if (ph == 0) begin
        beats_pending.push_back(mk(OP_WRITE, 15'h7FFF, '1, '1, '1, '1, '1, 1));
        beats_pending.push_back(mk(OP_NONE, 0, 0, 0, 0, 0, 0, 1));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h10000, 32'h10000, 5, 1));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0, 1));
        beats_pending.push_back(mk(OP_ZQUERY, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0));
      end else if (ph == 1) begin
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'hFFFF8000, 32'hFFFF0000, 3, 0));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h18000, 32'h24000, 3, 1));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h50000, 32'h2C000, 3, 0));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h38000, 32'h90000, 3, 0));
        beats_pending.push_back(mk(OP_ZQUERY, 0, 0, 0, 32'h30000, 32'h14000, 3, 1));
        beats_pending.push_back(mk(OP_ZQUERY, 0, 0, 0, 0, 32'hFFFE0000, 3, 0));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h18000, 32'h18000, 2, 1));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 3, 0));
        beats_pending.push_back(mk(OP_QUERY, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF, 3, 1));
      end else begin
        for (k = 0; k < RAND_BEATS; k++) begin
          r  = $urandom_range(99);
          zn = ($urandom_range(99) < 85) ? zone_reg : 4'($urandom);
          if (r < 70)
            beats_pending.push_back(mk(r < 50 ? OP_QUERY : OP_ZQUERY, $urandom, $urandom,
                                       $urandom, pick_pos(org_x, inv_x, nx),
                                       pick_pos(org_z, inv_z, nz), zn, $urandom));
          else if (r < 85)   // rewrite a node in use
            beats_pending.push_back(mk(OP_WRITE, $urandom_range(0, used - 1), pick_vel(),
                                       pick_vel(), $urandom, $urandom, $urandom, $urandom));
          else if (r < 95)   // write anywhere in the store
            beats_pending.push_back(mk(OP_WRITE, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom));
          else
            beats_pending.push_back(mk(OP_NONE, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, zn, $urandom));
        end
      end
      drain();
    end

    if (samples_due.size() != 0) begin
      $error("%0d expected results never arrived", samples_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
